@@ sv/tiled_texture_decoder_core_assert.svh @@
// Assertion macros for the texture decoder core RTL
`ifndef TILED_TEXTURE_DECODER_CORE_ASSERT_SVH
`define TILED_TEXTURE_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("texture decoder assertion failed");
`define TTD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("texture decoder assertion failed");
`else
`define TTD_ASSERT_IMP(lbl, ante, cons)
`define TTD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/ttd_pkg.sv @@
// Types, constants and colour helpers for the tiled texture decoder
`timescale 1ns / 1ps
`default_nettype none
package ttd_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int DIM_W         = 11;
    localparam int POS_W         = 12;
    localparam int COORD_W       = 10;

    typedef enum logic [3:0] {
        FMT_I4     = 4'd0,
        FMT_I8     = 4'd1,
        FMT_IA4    = 4'd2,
        FMT_IA8    = 4'd3,
        FMT_RGB565 = 4'd4,
        FMT_RGB5A3 = 4'd5,
        FMT_RGBA8  = 4'd6,
        FMT_C4     = 4'd7,
        FMT_C8     = 4'd8,
        FMT_CMPR   = 4'd9
    } texel_fmt_t;

    typedef enum logic [1:0] {
        PAL_IA8    = 2'd0,
        PAL_RGB565 = 2'd1,
        PAL_RGB5A3 = 2'd2,
        PAL_BLACK  = 2'd3
    } pal_fmt_t;

    typedef enum logic [1:0] {
        REG_TEXEL_FORMAT   = 2'd0,
        REG_PALETTE_FORMAT = 2'd1,
        REG_IMAGE_WIDTH    = 2'd2,
        REG_IMAGE_HEIGHT   = 2'd3
    } reg_index_t;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    typedef struct packed {
        logic       present;
        logic [2:0] dx;
        logic [2:0] dy;
    } pix_off_t;

    typedef struct packed {
        logic [3:0]         fmt;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [15:0]        raw;
        logic [15:0]        c1;
        logic [1:0]         sel;
        logic [15:0]        ar;
        logic               last_item;
        logic               last_image;
    } pix_stage_t;

    typedef logic [31:0][7:0] tab5_t;
    typedef logic [63:0][7:0] tab6_t;
    typedef logic [7:0][7:0]  tab3_t;

    function automatic tab5_t build_scale5();
        tab5_t t;
        for (int i = 0; i < 32; i++)
            t[i] = 8'((i * 255) / 31);
        return t;
    endfunction

    function automatic tab6_t build_scale6();
        tab6_t t;
        for (int i = 0; i < 64; i++)
            t[i] = 8'((i * 255) / 63);
        return t;
    endfunction

    function automatic tab3_t build_scale3();
        tab3_t t;
        for (int i = 0; i < 8; i++)
            t[i] = 8'((i * 255) / 7);
        return t;
    endfunction

    localparam tab5_t SCALE5 = build_scale5();
    localparam tab6_t SCALE6 = build_scale6();
    localparam tab3_t SCALE3 = build_scale3();

    function automatic rgba_t from_565(input logic [15:0] v);
        rgba_t c;
        c.r = SCALE5[v[15:11]];
        c.g = SCALE6[v[10:5]];
        c.b = SCALE5[v[4:0]];
        c.a = 8'hFF;
        return c;
    endfunction

    function automatic rgba_t from_5a3(input logic [15:0] v);
        rgba_t c;
        if (v[15])
        begin
            c.r = SCALE5[v[14:10]];
            c.g = SCALE5[v[9:5]];
            c.b = SCALE5[v[4:0]];
            c.a = 8'hFF;
        end
        else
        begin
            c.r = {v[11:8], v[11:8]};
            c.g = {v[7:4], v[7:4]};
            c.b = {v[3:0], v[3:0]};
            c.a = SCALE3[v[14:12]];
        end
        return c;
    endfunction

    // floor(v / 3) for v below 768
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [19:0] p;
        p = 20'(v) * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    function automatic pix_off_t pix_offset(input logic [3:0] fmt,
                                            input logic [2:0] k,
                                            input logic [3:0] i);
        pix_off_t o;
        o = '0;
        case (fmt)
            FMT_I4, FMT_C4:
            begin
                o.present = 1'b1;
                o.dx      = i[2:0];
                o.dy      = {k[1:0], i[3]};
            end
            FMT_I8, FMT_IA4, FMT_C8:
            begin
                o.present = !i[3];
                o.dx      = i[2:0];
                o.dy      = {1'b0, k[1:0]};
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3:
            begin
                o.present = (i[3:2] == 2'b00);
                o.dx      = {1'b0, i[1:0]};
                o.dy      = {1'b0, k[1:0]};
            end
            FMT_RGBA8:
            begin
                o.present = (i[3:2] == 2'b00) && k[2];
                o.dx      = {1'b0, i[1:0]};
                o.dy      = {1'b0, k[1:0]};
            end
            FMT_CMPR:
            begin
                o.present = 1'b1;
                o.dx      = {k[0], i[1:0]};
                o.dy      = {k[1], i[3:2]};
            end
            default:
            begin
                o = '0;
            end
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

@@ sv/ttd_channels.sv @@
// Channel interfaces: source chunks, decoded pixels and register writes
`timescale 1ns / 1ps
`default_nettype none
interface ttd_chunk_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] source_bytes;
    logic [7:0]  palette_index;
    logic [15:0] palette_entry;
    modport source (output valid, command, source_bytes, palette_index, palette_entry,
                    input ready);
    modport sink (input valid, command, source_bytes, palette_index, palette_entry,
                  output ready);
endinterface

interface ttd_pixel_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_item;
    logic       last_of_image;
    modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha,
                    last_of_item, last_of_image, input ready);
    modport sink (input valid, pixel_x, pixel_y, red, green, blue, alpha,
                  last_of_item, last_of_image, output ready);
endinterface

interface ttd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/ttd_ram.sv @@
// Generic simple dual-port RAM, read-first, registered read
`timescale 1ns / 1ps
`default_nettype none
module ttd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/ttd_pixel_decode.sv @@
// Colour decode of one staged pixel into RGBA8
`timescale 1ns / 1ps
`default_nettype none
module ttd_pixel_decode (
    input  wire logic [3:0]    fmt,
    input  wire logic [1:0]    pal_fmt,
    input  wire logic [15:0]   raw,
    input  wire logic [15:0]   c1,
    input  wire logic [1:0]    sel,
    input  wire logic [15:0]   ar,
    input  wire logic [15:0]   pal_word,
    output ttd_pkg::rgba_t     color
);
    import ttd_pkg::*;

    rgba_t pal_color;
    rgba_t p0;
    rgba_t p1;
    rgba_t mix;
    logic  gt;

    always_comb
    begin
        case (pal_fmt)
            PAL_IA8:    pal_color = '{pal_word[7:0], pal_word[7:0], pal_word[7:0],
                                      pal_word[15:8]};
            PAL_RGB565: pal_color = from_565(pal_word);
            PAL_RGB5A3: pal_color = from_5a3(pal_word);
            default:    pal_color = '{8'h00, 8'h00, 8'h00, 8'hFF};
        endcase
    end

    // DXT1 third/fourth entries; sel[0] picks double-weight end, or midpoint/black
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic g, input logic s);
        logic [7:0] u;
        logic [7:0] v;
        logic [8:0] half;
        u    = s ? b : a;
        v    = s ? a : b;
        half = 9'(a) + 9'(b);
        if (g)
            return div3(10'({u, 1'b0}) + 10'(v) + 10'd1);
        else if (s)
            return 8'h00;
        else
            return half[8:1];
    endfunction

    always_comb
    begin
        p0    = from_565(raw);
        p1    = from_565(c1);
        gt    = raw > c1;
        mix.r = blend(p0.r, p1.r, gt, sel[0]);
        mix.g = blend(p0.g, p1.g, gt, sel[0]);
        mix.b = blend(p0.b, p1.b, gt, sel[0]);
        mix.a = (gt || !sel[0]) ? 8'hFF : 8'h00;
    end

    always_comb
    begin
        case (fmt)
            FMT_I4:     color = '{{raw[3:0], raw[3:0]}, {raw[3:0], raw[3:0]},
                                  {raw[3:0], raw[3:0]}, 8'hFF};
            FMT_I8:     color = '{raw[7:0], raw[7:0], raw[7:0], 8'hFF};
            FMT_IA4:    color = '{{raw[3:0], raw[3:0]}, {raw[3:0], raw[3:0]},
                                  {raw[3:0], raw[3:0]}, {raw[7:4], raw[7:4]}};
            FMT_IA8:    color = '{raw[7:0], raw[7:0], raw[7:0], raw[15:8]};
            FMT_RGB565: color = from_565(raw);
            FMT_RGB5A3: color = from_5a3(raw);
            FMT_RGBA8:  color = '{ar[7:0], raw[15:8], raw[7:0], ar[15:8]};
            FMT_C4, FMT_C8: color = pal_color;
            FMT_CMPR:
            begin
                case (sel)
                    2'd0:    color = p0;
                    2'd1:    color = p1;
                    default: color = mix;
                endcase
            end
            default:    color = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/tiled_texture_decoder_core.sv @@
// Top level of the tiled texture decoder
//
//  channel  dir  beat                               payload
//  chunk    in   one 8-byte chunk or palette write  command, source_bytes, palette_*
//  pixel    out  one decoded pixel                  pixel_x/y, RGBA, last flags
//  cfg      in   one register write                 index, data
//
// A chunk emits 0 to 16 pixels on the single pixel lane, one per cycle while the
// output takes them; palette writes and empty chunks leave the chunk channel ready.
// The first pixel passes pixel select into the stage register (palette RAM read
// alongside), then colour decode into the output register.
// The next chunk is taken in the cycle its predecessor's last pixel moves on.
// Reset clears position, resets config; palette and RGBA8 buffer are not cleared.
// A stalled output holds its beat; stalls back up to the chunk channel.
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_texture_decoder_core_assert.svh"
module tiled_texture_decoder_core (
    input wire logic clk,
    input wire logic rst_n,
    ttd_chunk_if.sink    chunk,
    ttd_pixel_if.source  pixel,
    ttd_cfg_if.sink      cfg
);
    import ttd_pkg::*;

    logic [3:0]        texel_format_reg;
    logic [1:0]        palette_format_reg;
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;

    logic [7:0]        tile_column_reg;
    logic [7:0]        tile_row_reg;
    logic [2:0]        chunk_in_tile_reg;

    logic [15:0]       ar_buf_reg [16];

    logic [15:0]       work_mask_reg;
    logic [63:0]       work_src_reg;
    logic [3:0]        work_fmt_reg;
    logic [2:0]        work_k_reg;
    logic [POS_W-1:0]  work_bx_reg;
    logic [POS_W-1:0]  work_by_reg;

    pix_stage_t        p_reg;
    pix_stage_t        p_next;
    logic              p_valid_reg;
    logic              o_valid_reg;
    logic [COORD_W-1:0] o_x_reg;
    logic [COORD_W-1:0] o_y_reg;
    rgba_t             o_col_reg;
    logic              o_last_item_reg;
    logic              o_last_image_reg;

    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic              fmt_ok;
    logic              tw4;
    logic              th8;
    logic              is_rgba;
    logic [2:0]        k;
    logic              last_chunk;
    logic [8:0]        cols;
    logic [8:0]        rows;
    logic [8:0]        col_plus;
    logic [8:0]        row_plus;
    logic [POS_W-1:0]  base_x;
    logic [POS_W-1:0]  base_y;
    logic [15:0]       new_mask;
    pix_off_t          off_new;

    logic              chunk_beat;
    logic              data_beat;
    logic              pal_beat;
    logic              o_ready;
    logic              p_ready;
    logic              a_fire;
    logic [15:0]       low_bit;
    logic              single;
    logic [3:0]        sel_i;
    pix_off_t          off;
    logic [POS_W-1:0]  ax;
    logic [POS_W-1:0]  ay;
    logic [7:0]        src_byte;
    logic [7:0]        nib_byte;
    logic [3:0]        nib;
    logic [15:0]       src_word;
    logic [1:0]        cmpr_sel;
    logic [PAL_AW-1:0] pal_raddr;
    logic [15:0]       pal_rdata;
    rgba_t             color;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_format_reg   <= FMT_I4;
            palette_format_reg <= PAL_IA8;
            image_width_reg    <= DIM_W'(8);
            image_height_reg   <= DIM_W'(8);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TEXEL_FORMAT:   texel_format_reg   <= cfg.data[3:0];
                REG_PALETTE_FORMAT: palette_format_reg <= cfg.data[1:0];
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg.data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // chunk geometry
    always_comb
    begin
        w          = clamp_dim(image_width_reg, DIM_W'(MAX_WIDTH));
        h          = clamp_dim(image_height_reg, DIM_W'(MAX_HEIGHT));
        fmt_ok     = texel_format_reg <= FMT_CMPR;
        tw4        = (texel_format_reg == FMT_IA8) || (texel_format_reg == FMT_RGB565) ||
                     (texel_format_reg == FMT_RGB5A3) || (texel_format_reg == FMT_RGBA8);
        th8        = (texel_format_reg == FMT_I4) || (texel_format_reg == FMT_C4) ||
                     (texel_format_reg == FMT_CMPR);
        is_rgba    = texel_format_reg == FMT_RGBA8;
        k          = is_rgba ? chunk_in_tile_reg : {1'b0, chunk_in_tile_reg[1:0]};
        last_chunk = is_rgba ? (k == 3'd7) : (k[1:0] == 2'd3);
        cols       = tw4 ? 9'((POS_W'(w) + POS_W'(3)) >> 2) : 9'((POS_W'(w) + POS_W'(7)) >> 3);
        rows       = th8 ? 9'((POS_W'(h) + POS_W'(7)) >> 3) : 9'((POS_W'(h) + POS_W'(3)) >> 2);
        col_plus   = 9'(tile_column_reg) + 9'd1;
        row_plus   = 9'(tile_row_reg) + 9'd1;
        base_x     = tw4 ? (POS_W'(tile_column_reg) << 2) : (POS_W'(tile_column_reg) << 3);
        base_y     = th8 ? (POS_W'(tile_row_reg) << 3) : (POS_W'(tile_row_reg) << 2);
        for (int i = 0; i < 16; i++)
        begin
            off_new     = pix_offset(texel_format_reg, k, 4'(i));
            new_mask[i] = off_new.present && (base_x + POS_W'(off_new.dx) < POS_W'(w)) &&
                          (base_y + POS_W'(off_new.dy) < POS_W'(h));
        end
    end

    // pixel lane control
    assign o_ready    = !o_valid_reg || pixel.ready;
    assign p_ready    = !p_valid_reg || o_ready;
    assign a_fire     = (work_mask_reg != '0) && p_ready;
    assign low_bit    = work_mask_reg & (~work_mask_reg + 16'd1);
    assign single     = work_mask_reg == low_bit;
    assign chunk.ready = (work_mask_reg == '0) || (a_fire && single);
    assign chunk_beat = chunk.valid && chunk.ready;
    assign data_beat  = chunk_beat && (chunk.command == CMD_DATA) && fmt_ok;
    assign pal_beat   = chunk_beat && (chunk.command == CMD_PALETTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_column_reg   <= '0;
            tile_row_reg      <= '0;
            chunk_in_tile_reg <= '0;
        end
        else if (data_beat)
        begin
            if (last_chunk)
            begin
                chunk_in_tile_reg <= '0;
                if (col_plus >= cols)
                begin
                    tile_column_reg <= '0;
                    tile_row_reg    <= (row_plus >= rows) ? 8'd0 : row_plus[7:0];
                end
                else
                begin
                    tile_column_reg <= col_plus[7:0];
                end
            end
            else
            begin
                chunk_in_tile_reg <= k + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_beat && is_rgba && !k[2])
        begin
            for (int i = 0; i < 4; i++)
                ar_buf_reg[{k[1:0], 2'(i)}] <= chunk.source_bytes[63 - 16 * i -: 16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_mask_reg <= '0;
        else if (chunk_beat)
            work_mask_reg <= data_beat ? new_mask : 16'd0;
        else if (a_fire)
            work_mask_reg <= work_mask_reg & ~low_bit;
    end

    always_ff @(posedge clk)
    begin
        if (data_beat)
        begin
            work_src_reg <= chunk.source_bytes;
            work_fmt_reg <= texel_format_reg;
            work_k_reg   <= k;
            work_bx_reg  <= base_x;
            work_by_reg  <= base_y;
        end
    end

    // pixel select
    always_comb
    begin
        sel_i = '0;
        for (int i = 0; i < 16; i++)
            if (low_bit[i])
                sel_i = sel_i | 4'(i);
        off      = pix_offset(work_fmt_reg, work_k_reg, sel_i);
        ax       = work_bx_reg + POS_W'(off.dx);
        ay       = work_by_reg + POS_W'(off.dy);
        src_byte = 8'(work_src_reg >> {~sel_i[2:0], 3'b000});
        nib_byte = 8'(work_src_reg >> {~sel_i[3:1], 3'b000});
        nib      = sel_i[0] ? nib_byte[3:0] : nib_byte[7:4];
        src_word = 16'(work_src_reg >> {~sel_i[1:0], 4'b0000});
        cmpr_sel = 2'(work_src_reg >> {~sel_i, 1'b0});

        p_next.fmt        = work_fmt_reg;
        p_next.x          = ax[COORD_W-1:0];
        p_next.y          = ay[COORD_W-1:0];
        p_next.c1         = work_src_reg[47:32];
        p_next.sel        = cmpr_sel;
        p_next.ar         = ar_buf_reg[{work_k_reg[1:0], sel_i[1:0]}];
        p_next.last_item  = single;
        p_next.last_image = (ax == POS_W'(w) - POS_W'(1)) && (ay == POS_W'(h) - POS_W'(1));
        case (work_fmt_reg)
            FMT_I4, FMT_C4:          p_next.raw = {12'd0, nib};
            FMT_I8, FMT_IA4, FMT_C8: p_next.raw = {8'd0, src_byte};
            FMT_CMPR:                p_next.raw = work_src_reg[63:48];
            default:                 p_next.raw = src_word;
        endcase
        pal_raddr = p_next.raw[PAL_AW-1:0];
    end

    ttd_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_beat),
        .waddr (chunk.palette_index[PAL_AW-1:0]),
        .wdata (chunk.palette_entry),
        .re    (a_fire),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (p_ready)
            p_valid_reg <= a_fire;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
            p_reg <= p_next;
    end

    // colour decode and output register
    ttd_pixel_decode u_decode (
        .fmt      (p_reg.fmt),
        .pal_fmt  (palette_format_reg),
        .raw      (p_reg.raw),
        .c1       (p_reg.c1),
        .sel      (p_reg.sel),
        .ar       (p_reg.ar),
        .pal_word (pal_rdata),
        .color    (color)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && p_valid_reg)
        begin
            o_x_reg          <= p_reg.x;
            o_y_reg          <= p_reg.y;
            o_col_reg        <= color;
            o_last_item_reg  <= p_reg.last_item;
            o_last_image_reg <= p_reg.last_image;
        end
    end

    assign pixel.valid         = o_valid_reg;
    assign pixel.pixel_x       = o_x_reg;
    assign pixel.pixel_y       = o_y_reg;
    assign pixel.red           = o_col_reg.r;
    assign pixel.green         = o_col_reg.g;
    assign pixel.blue          = o_col_reg.b;
    assign pixel.alpha         = o_col_reg.a;
    assign pixel.last_of_item  = o_last_item_reg;
    assign pixel.last_of_image = o_last_image_reg;

    `TTD_ASSERT_IMP(a_image_end_ends_chunk, pixel.valid && pixel.last_of_image, pixel.last_of_item)
    `TTD_ASSERT_IMP(a_take_on_last_pixel, chunk_beat, (work_mask_reg == '0) || single)
    `TTD_ASSERT_IMP(a_work_fmt_valid, work_mask_reg != '0, work_fmt_reg <= FMT_CMPR)
    `TTD_ASSERT_NXT(a_palette_emits_none, pal_beat, work_mask_reg == '0)
endmodule
`default_nettype wire
